[rtl/csllc_pkg.sv]
// Package for the C subset lexer classifier: token class codes, keyword table,
// character class functions and the word classification helpers.
// No dependencies.
package csllc_pkg;

    localparam int MAX_TOKEN_LEN = 255;
    localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
    localparam int NUM_KW        = 9;
    localparam int KW_MAX_LEN    = 8;

    localparam logic [7:0] CH_SLASH      = 8'h2f;
    localparam logic [7:0] CH_STAR       = 8'h2a;
    localparam logic [7:0] CH_NEWLINE    = 8'h0a;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5f;

    typedef enum logic [2:0] {
        CLS_NONE    = 3'd0,
        CLS_KEYWORD = 3'd1,
        CLS_PUNCT   = 3'd2,
        CLS_OPER    = 3'd3,
        CLS_CONST   = 3'd4,
        CLS_IDENT   = 3'd5,
        CLS_INVALID = 3'd6
    } token_class_t;

    // int, char, return, if, else, while, for, break, continue
    localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
        '{8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h63, 8'h68, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e, 8'h00, 8'h00},
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h77, 8'h68, 8'h69, 8'h6c, 8'h65, 8'h00, 8'h00, 8'h00},
        '{8'h66, 8'h6f, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h62, 8'h72, 8'h65, 8'h61, 8'h6b, 8'h00, 8'h00, 8'h00},
        '{8'h63, 8'h6f, 8'h6e, 8'h74, 8'h69, 8'h6e, 8'h75, 8'h65}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd3, 4'd4, 4'd6, 4'd2, 4'd4, 4'd5, 4'd3, 4'd5, 4'd8
    };

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [NUM_KW-1:0] mask;
        logic              digits;
        logic              ident;
    } word_t;

    typedef struct packed {
        token_class_t cls;
        logic [3:0]   kwi;
        logic [7:0]   sym;
        logic [7:0]   len;
        logic         last;
    } result_t;

    localparam word_t WORD_RESET = '{len: '0, mask: '1, digits: 1'b1, ident: 1'b1};

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    endfunction

    function automatic logic is_punct(logic [7:0] c);
        return (c == 8'h3b) || (c == 8'h2c) || (c == 8'h28) || (c == 8'h29) ||
               (c == 8'h7b) || (c == 8'h7d);
    endfunction

    function automatic logic is_oper(logic [7:0] c);
        return (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2a) || (c == 8'h2f) ||
               (c == 8'h3d) || (c == 8'h3e) || (c == 8'h3c) || (c == 8'h21);
    endfunction

    // Append one byte to the word being built.
    function automatic word_t word_add(word_t w, logic [7:0] c);
        word_t r;
        r = w;
        for (int k = 0; k < NUM_KW; k++) begin
            if ((w.len >= LEN_W'(KW_LEN[k])) || (KW_TEXT[k][w.len[2:0]] != c)) begin
                r.mask[k] = 1'b0;
            end
        end
        if (!is_digit(c)) begin
            r.digits = 1'b0;
        end
        if (w.len == '0) begin
            r.ident = is_alpha(c) || (c == CH_UNDERSCORE);
        end else if (!(is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE))) begin
            r.ident = 1'b0;
        end
        if (w.len < LEN_W'(MAX_TOKEN_LEN)) begin
            r.len = w.len + 1'b1;
        end
        return r;
    endfunction

    // Classify a finished word; the lowest matching keyword wins.
    function automatic result_t word_result(word_t w);
        result_t r;
        logic    hit;
        r   = '{cls: CLS_INVALID, kwi: 4'd0, sym: 8'd0, len: 8'(w.len), last: 1'b0};
        hit = 1'b0;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (w.mask[k] && (w.len == LEN_W'(KW_LEN[k]))) begin
                hit   = 1'b1;
                r.kwi = 4'(k);
            end
        end
        if (hit) begin
            r.cls = CLS_KEYWORD;
        end else if (w.digits) begin
            r.cls = CLS_CONST;
        end else if (w.ident) begin
            r.cls = CLS_IDENT;
        end
        return r;
    endfunction

    function automatic result_t sym_result(token_class_t cls, logic [7:0] c);
        return '{cls: cls, kwi: 4'd0, sym: c, len: 8'd1, last: 1'b0};
    endfunction

endpackage

[rtl/c_subset_lexer_classifier_unit.sv]
// Streaming lexer for a small C subset: one source byte in, zero to three
// token words out. Depends on csllc_pkg.
//
// A token word is written to the result queue when the byte that completes
//   it is accepted, and is offered at the output from the queue in order.
// Throughput, while out_ready is high: one byte per cycle while each byte
//   yields at most one token; a byte that yields two or three tokens holds
//   input until the four-entry result queue drains to one entry (one token leaves per cycle).
// Reset: asynchronous, active low; clears the scanner state to "no word,
//   no comment, no pending slash" and empties the result queue.
module c_subset_lexer_classifier_unit
    import csllc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_byte,
    input  logic       end_of_input,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] token_class,
    output logic [3:0] keyword_index,
    output logic [7:0] symbol_char,
    output logic [7:0] token_length,
    output logic       last_result
);

    // Scanner state
    logic    slash_pending_reg,     slash_pending_next;
    logic    in_block_comment_reg,  in_block_comment_next;
    logic    comment_star_seen_reg, comment_star_seen_next;
    logic    in_line_comment_reg,   in_line_comment_next;
    word_t   word_reg,              word_next;

    // Result queue: four entries, up to three written per accepted byte
    result_t     res_mem_reg [4];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  rd_ptr_reg;
    logic [2:0]  count_reg;

    logic        accept;
    logic        pop;

    // Byte decode
    logic    c_slash, c_star, c_space, c_punct, c_oper, c_newline;
    logic    pend_flush;      // pending slash turns out to be a divide operator
    logic    active;          // byte goes through the normal token path
    logic    act_slash, act_sep, act_sym, act_add;
    logic    word_valid;
    word_t   word_base;       // word after a pending-slash flush
    word_t   word_after;      // word after this byte, before end-of-input flush

    logic    emit_w1, emit_s1, emit_sym, emit_w2, emit_s2;
    result_t w1_res, slash_res, sym_res, w2_res;
    result_t slot [3];
    logic [1:0] push_cnt;

    assign accept = in_valid && in_ready;
    assign pop    = out_valid && out_ready;

    // Take a byte only while three entries are free.
    assign in_ready  = (count_reg <= 3'd1);
    assign out_valid = (count_reg != 3'd0);

    always_comb
    begin
        c_slash   = (char_byte == CH_SLASH);
        c_star    = (char_byte == CH_STAR);
        c_newline = (char_byte == CH_NEWLINE);
        c_space   = is_space(char_byte);
        c_punct   = is_punct(char_byte);
        c_oper    = is_oper(char_byte) && !c_slash;
        word_valid = (word_reg.len != '0);

        pend_flush = !in_block_comment_reg && !in_line_comment_reg && slash_pending_reg &&
                     !c_slash && !c_star;
        active     = !in_block_comment_reg && !in_line_comment_reg &&
                     !(slash_pending_reg && (c_slash || c_star));
        word_base  = pend_flush ? WORD_RESET : word_reg;

        act_slash = active && c_slash;
        act_sym   = active && (c_punct || c_oper);
        act_sep   = active && (c_space || c_punct || c_oper);
        act_add   = active && !c_slash && !c_space && !c_punct && !c_oper;

        // Word before the byte ends on a divide, a separator, or a newline
        // that closes a line comment.
        emit_w1  = word_valid && (pend_flush || act_sep ||
                   (!in_block_comment_reg && in_line_comment_reg && c_newline));
        emit_s1  = pend_flush;
        emit_sym = act_sym;

        // Comment tracking
        in_block_comment_next  = in_block_comment_reg;
        comment_star_seen_next = comment_star_seen_reg;
        in_line_comment_next   = in_line_comment_reg;
        slash_pending_next     = act_slash;
        word_after             = word_reg;
        if (in_block_comment_reg) begin
            if (comment_star_seen_reg && c_slash) begin
                in_block_comment_next  = 1'b0;
                comment_star_seen_next = 1'b0;
            end else begin
                comment_star_seen_next = c_star;
            end
        end else if (in_line_comment_reg) begin
            if (c_newline) begin
                in_line_comment_next = 1'b0;
                word_after           = WORD_RESET;
            end
        end else if (!active) begin
            // Pending slash opens a comment; the word goes on across it.
            in_line_comment_next   = c_slash;
            in_block_comment_next  = c_star;
            comment_star_seen_next = 1'b0;
        end else if (act_add) begin
            word_after = word_add(word_base, char_byte);
        end else if (act_sep) begin
            word_after = WORD_RESET;
        end else begin
            word_after = word_base;
        end

        // End of input flushes the word, then a pending slash.
        emit_w2 = end_of_input && (word_after.len != '0);
        emit_s2 = end_of_input && slash_pending_next;

        word_next = word_after;
        if (end_of_input) begin
            slash_pending_next     = 1'b0;
            in_block_comment_next  = 1'b0;
            comment_star_seen_next = 1'b0;
            in_line_comment_next   = 1'b0;
            word_next              = WORD_RESET;
        end
    end

    // Pack the emitted tokens into consecutive slots.
    always_comb
    begin
        w1_res    = word_result(word_reg);
        w2_res    = word_result(word_after);
        slash_res = sym_result(CLS_OPER, CH_SLASH);
        sym_res   = sym_result(c_punct ? CLS_PUNCT : CLS_OPER, char_byte);

        slot     = '{default: '0};
        push_cnt = 2'd0;
        if (emit_w1) begin
            slot[push_cnt] = w1_res;
            push_cnt       = push_cnt + 2'd1;
        end
        if (emit_s1) begin
            slot[push_cnt] = slash_res;
            push_cnt       = push_cnt + 2'd1;
        end
        if (emit_sym) begin
            slot[push_cnt] = sym_res;
            push_cnt       = push_cnt + 2'd1;
        end
        if (emit_w2) begin
            slot[push_cnt] = w2_res;
            push_cnt       = push_cnt + 2'd1;
        end
        if (emit_s2) begin
            slot[push_cnt] = slash_res;
            push_cnt       = push_cnt + 2'd1;
        end
        // End of input with nothing to report: send the end marker.
        if (end_of_input && (push_cnt == 2'd0)) begin
            slot[0]  = '{cls: CLS_NONE, kwi: 4'd0, sym: 8'd0, len: 8'd0, last: 1'b0};
            push_cnt = 2'd1;
        end
        if (end_of_input) begin
            slot[push_cnt - 2'd1].last = 1'b1;
        end
    end

    // Scanner state registers: advance only on an accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slash_pending_reg     <= 1'b0;
            in_block_comment_reg  <= 1'b0;
            comment_star_seen_reg <= 1'b0;
            in_line_comment_reg   <= 1'b0;
            word_reg              <= WORD_RESET;
        end else if (accept) begin
            slash_pending_reg     <= slash_pending_next;
            in_block_comment_reg  <= in_block_comment_next;
            comment_star_seen_reg <= comment_star_seen_next;
            in_line_comment_reg   <= in_line_comment_next;
            word_reg              <= word_next;
        end
    end

    // Queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            if (accept) begin
                wr_ptr_reg <= wr_ptr_reg + push_cnt;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (accept ? 3'(push_cnt) : 3'd0) - 3'(pop);
        end
    end

    // Queue payload: no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < push_cnt) begin
                    res_mem_reg[wr_ptr_reg + 2'(i)] <= slot[i];
                end
            end
        end
    end

    assign token_class   = res_mem_reg[rd_ptr_reg].cls;
    assign keyword_index = res_mem_reg[rd_ptr_reg].kwi;
    assign symbol_char   = res_mem_reg[rd_ptr_reg].sym;
    assign token_length  = res_mem_reg[rd_ptr_reg].len;
    assign last_result   = res_mem_reg[rd_ptr_reg].last;

    // Queue never overfills.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 3'd4)
        else $error("result queue overflow");

    // An end-of-input byte always queues at least one word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_input) |=> (count_reg != 3'd0))
        else $error("end of input produced no result");

    // End of input returns the scanner to its reset state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_input) |=> (word_reg.len == '0 && !slash_pending_reg &&
                                      !in_block_comment_reg && !in_line_comment_reg))
        else $error("scanner state not cleared after end of input");

    // Comment modes and the pending slash exclude each other.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({slash_pending_reg, in_block_comment_reg, in_line_comment_reg}) <= 1)
        else $error("conflicting scanner modes");

endmodule
